FILE: src/bn_pkg.sv
package bn_pkg;

    // Number format and table depth.
    localparam int CHANNELS   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EPS_W      = 16;

    // Load arithmetic: radicand is (variance + epsilon) << FRAC_BITS.
    localparam int RAD_W      = 32 + FRAC_BITS;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int DIV_STEPS  = 64;

    // Job queue between front and back.
    localparam int QDEPTH     = 2;
    localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;
    localparam logic signed [63:0] HUGE   = 64'sh1FFF_FFFF_FFFF_FFFF;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_NORM = 1'b1
    } op_t;

    typedef struct packed
    {
        logic               opcode;
        logic [5:0]         channel;
        logic signed [31:0] sample;
        logic signed [31:0] beta_in;
        logic signed [31:0] gamma_in;
        logic signed [31:0] mean_in;
        logic [30:0]        variance_in;
    } cmd_word_t;

    typedef struct packed
    {
        logic [5:0]         channel_out;
        logic signed [31:0] result;
        logic               saturated;
    } rsp_word_t;

    typedef struct packed
    {
        op_t                op;
        logic               in_range;
        logic [5:0]         channel;
        logic signed [31:0] sample;
        logic signed [31:0] beta;
        logic signed [31:0] gamma;
        logic signed [31:0] mean;
        logic [30:0]        variance;
    } job_t;

    typedef struct packed
    {
        logic               hit;
        logic signed [31:0] value;
    } sat_t;

    // Clip a wide signed value to the DATA_WIDTH signed range.
    function automatic sat_t saturate(input logic signed [64:0] v);
        sat_t r;
        r.hit   = 1'b0;
        r.value = 32'(v);
        if (v > SAT_HI)
        begin
            r.hit   = 1'b1;
            r.value = 32'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r.hit   = 1'b1;
            r.value = 32'(SAT_LO);
        end
        return r;
    endfunction

endpackage

FILE: src/bn_front.sv
module bn_front
    import bn_pkg::*;
(
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,
    input  logic      q_full,
    output logic      push,
    output job_t      job
);

    // Decode the opcode and check the channel against the table depth.
    always_comb
    begin
        job.op       = op_t'(cmd_word.opcode);
        job.in_range = (32'(cmd_word.channel) < CHANNELS);
        job.channel  = cmd_word.channel;
        job.sample   = cmd_word.sample;
        job.beta     = cmd_word.beta_in;
        job.gamma    = cmd_word.gamma_in;
        job.mean     = cmd_word.mean_in;
        job.variance = cmd_word.variance_in;
    end

    assign cmd_stall = q_full;
    assign push      = cmd_valid & ~q_full;

endmodule

FILE: src/bn_queue.sv
module bn_queue
    import bn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t             entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/bn_loadcalc.sv
module bn_loadcalc
    import bn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [EPS_W-1:0]   epsilon,
    input  logic [30:0]        variance,
    input  logic signed [31:0] gamma,
    input  logic signed [31:0] beta,
    input  logic signed [63:0] product,
    output logic               done,
    output logic signed [31:0] scale,
    output logic signed [31:0] offset
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W = ROOT_W + 3;

    typedef enum logic [1:0]
    {
        LC_IDLE,
        LC_SQRT,
        LC_DIV_SC,
        LC_DIV_TERM
    } lc_state_t;

    lc_state_t                state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [2*ROOT_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [ROOT_W:0]          drem_reg, drem_next;
    logic [63:0]              dvd_reg, dvd_next;
    logic [63:0]              pmag_reg, pmag_next;
    logic                     gneg_reg, gneg_next;
    logic                     gzero_reg, gzero_next;
    logic                     pneg_reg, pneg_next;
    logic                     pzero_reg, pzero_next;
    logic signed [31:0]       beta_reg, beta_next;
    logic signed [31:0]       scale_reg, scale_next;
    logic signed [31:0]       offset_reg, offset_next;

    logic [31:0]              var_sum;
    logic [32:0]              g_ext;
    logic [31:0]              gmag;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         trial;
    logic [ROOT_W:0]          drem_sh;
    logic signed [63:0]       q_signed;
    logic signed [63:0]       sc_ext;
    logic signed [63:0]       term_ext;
    sat_t                     sat_sc;
    sat_t                     sat_off;

    assign done   = done_reg;
    assign scale  = scale_reg;
    assign offset = offset_reg;

    always_comb
    begin
        var_sum  = 32'(variance) + 32'(epsilon);
        g_ext    = 33'(gamma);
        gmag     = gamma[31] ? 32'(~g_ext + 33'd1) : g_ext[31:0];
        rem_sh   = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial    = REM_W'({root_reg, 2'b01});
        drem_sh  = {drem_reg[ROOT_W-1:0], dvd_reg[63]};
        q_signed = 64'sd0;
        sc_ext   = 64'sd0;
        term_ext = 64'sd0;
        sat_sc   = saturate(65'sd0);
        sat_off  = saturate(65'sd0);

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        drem_next   = drem_reg;
        dvd_next    = dvd_reg;
        pmag_next   = pmag_reg;
        gneg_next   = gneg_reg;
        gzero_next  = gzero_reg;
        pneg_next   = pneg_reg;
        pzero_next  = pzero_reg;
        beta_next   = beta_reg;
        scale_next  = scale_reg;
        offset_next = offset_reg;

        case (state_reg)
            LC_IDLE:
            begin
                if (start)
                begin
                    rad_next   = (2*ROOT_W)'(var_sum) << FRAC_BITS;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(SQ_STEPS - 1);
                    gneg_next  = gamma[31];
                    gzero_next = (gamma == 32'sd0);
                    pneg_next  = product[63];
                    pzero_next = (product == 64'sd0);
                    pmag_next  = product[63] ? 64'(-product) : 64'(product);
                    dvd_next   = 64'(gmag) << FRAC_BITS;
                    beta_next  = beta;
                    state_next = LC_SQRT;
                end
            end

            LC_SQRT:
            begin
                // Two radicand bits per cycle, restoring digit recurrence.
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (root_next == '0)
                    begin
                        // Zero root: each term goes to the extreme of its sign, or to zero if its numerator is zero.
                        sc_ext      = gzero_reg ? 64'sd0 : (gneg_reg ? -HUGE : HUGE);
                        term_ext    = pzero_reg ? 64'sd0 : (pneg_reg ? -HUGE : HUGE);
                        sat_sc      = saturate(65'(sc_ext));
                        sat_off     = saturate(65'(beta_reg) - 65'(term_ext));
                        scale_next  = sat_sc.value;
                        offset_next = sat_off.value;
                        done_next   = 1'b1;
                        state_next  = LC_IDLE;
                    end
                    else
                    begin
                        drem_next  = '0;
                        cnt_next   = CNT_W'(DIV_STEPS - 1);
                        state_next = LC_DIV_SC;
                    end
                end
            end

            LC_DIV_SC, LC_DIV_TERM:
            begin
                // One quotient bit per cycle; the quotient shifts into the dividend.
                if (drem_sh >= (ROOT_W+1)'(root_reg))
                begin
                    drem_next = drem_sh - (ROOT_W+1)'(root_reg);
                    dvd_next  = {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_sh;
                    dvd_next  = {dvd_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == LC_DIV_SC)
                    begin
                        q_signed   = gneg_reg ? -$signed(dvd_next) : $signed(dvd_next);
                        sat_sc     = saturate(65'(q_signed));
                        scale_next = sat_sc.value;
                        dvd_next   = pmag_reg;
                        drem_next  = '0;
                        cnt_next   = CNT_W'(DIV_STEPS - 1);
                        state_next = LC_DIV_TERM;
                    end
                    else
                    begin
                        q_signed    = pneg_reg ? -$signed(dvd_next) : $signed(dvd_next);
                        sat_off     = saturate(65'(beta_reg) - 65'(q_signed));
                        offset_next = sat_off.value;
                        done_next   = 1'b1;
                        state_next  = LC_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = LC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        dvd_reg    <= dvd_next;
        pmag_reg   <= pmag_next;
        gneg_reg   <= gneg_next;
        gzero_reg  <= gzero_next;
        pneg_reg   <= pneg_next;
        pzero_reg  <= pzero_next;
        beta_reg   <= beta_next;
        scale_reg  <= scale_next;
        offset_reg <= offset_next;
    end

endmodule

FILE: src/bn_back.sv
module bn_back
    import bn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [EPS_W-1:0] epsilon,
    input  logic             q_not_empty,
    input  job_t             q_head,
    output logic             q_pop,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_word_t        rsp_word
);

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_NORM_MUL,
        BK_NORM_FIN,
        BK_LOAD_MUL,
        BK_LOAD_START,
        BK_LOAD_WAIT
    } bk_state_t;

    bk_state_t          state_reg;
    job_t               job_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] off_reg;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_word_reg;

    logic signed [31:0] scale_mem  [CHANNELS];
    logic signed [31:0] offset_mem [CHANNELS];
    logic signed [31:0] rd_scale_reg;
    logic signed [31:0] rd_offset_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] bias;
    logic signed [63:0] shifted;
    sat_t               norm_sat;
    logic               slot_free;
    logic               rsp_load;
    logic               lc_start;
    logic               lc_done;
    logic signed [31:0] lc_scale;
    logic signed [31:0] lc_offset;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;
    assign q_pop     = (state_reg == BK_IDLE) && q_not_empty;
    assign lc_start  = (state_reg == BK_LOAD_START);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == BK_NORM_FIN) && slot_free;

    bn_loadcalc u_loadcalc
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lc_start),
        .epsilon  (epsilon),
        .variance (job_reg.variance),
        .gamma    (job_reg.gamma),
        .beta     (job_reg.beta),
        .product  (prod_reg),
        .done     (lc_done),
        .scale    (lc_scale),
        .offset   (lc_offset)
    );

    // The one multiplier serves gamma*mean on loads and scale*x on samples.
    always_comb
    begin
        if (state_reg == BK_LOAD_MUL)
        begin
            mul_a = job_reg.gamma;
            mul_b = job_reg.mean;
        end
        else
        begin
            mul_a = job_reg.in_range ? rd_scale_reg : 32'sd0;
            mul_b = job_reg.sample;
        end
        bias     = prod_reg[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0;
        shifted  = (prod_reg + bias) >>> FRAC_BITS;
        norm_sat = saturate(65'(shifted) + 65'(off_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        job_reg   <= q_head;
                        state_reg <= (q_head.op == OP_NORM) ? BK_NORM_MUL : BK_LOAD_MUL;
                    end
                end

                BK_NORM_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    off_reg   <= job_reg.in_range ? rd_offset_reg : 32'sd0;
                    state_reg <= BK_NORM_FIN;
                end

                BK_NORM_FIN:
                begin
                    if (slot_free)
                    begin
                        rsp_word_reg.channel_out <= job_reg.channel;
                        rsp_word_reg.result      <= norm_sat.value;
                        rsp_word_reg.saturated   <= norm_sat.hit;
                        state_reg                <= BK_IDLE;
                    end
                end

                BK_LOAD_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= BK_LOAD_START;
                end

                BK_LOAD_START:
                begin
                    state_reg <= BK_LOAD_WAIT;
                end

                BK_LOAD_WAIT:
                begin
                    if (lc_done)
                    begin
                        state_reg <= BK_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    // Parameter tables; the read data is registered, ready in the cycle after the address is presented.
    always_ff @(posedge clk)
    begin
        rd_scale_reg  <= scale_mem[CH_AW'(q_head.channel)];
        rd_offset_reg <= offset_mem[CH_AW'(q_head.channel)];
        if ((state_reg == BK_LOAD_WAIT) && lc_done && job_reg.in_range)
        begin
            scale_mem[CH_AW'(job_reg.channel)]  <= lc_scale;
            offset_mem[CH_AW'(job_reg.channel)] <= lc_offset;
        end
    end

endmodule

FILE: src/batch_norm_inference.sv
// Channel    Handshake                 Payload
// cmd        cmd_valid / cmd_stall     cmd_word (load or normalize word)
// rsp        rsp_valid / rsp_stall     rsp_word (one word per normalize)
// epsilon    epsilon_we                epsilon_data (no read-back)
//
// A normalize word goes through the back end as table read, multiply, then
// the rounding add, offset add and clip into the output register.
// A load word holds the back end through pop, multiply and start, 24 root
// steps, two 64-step divides and the wait for done; a zero root skips the divides.
// Reset clears control state and sets epsilon to 66; the tables hold no reset value.
// A stalled rsp word holds the back end; the two-word queue keeps taking cmd words until full.
module batch_norm_inference
    import bn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_word_t        cmd_word,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_word_t        rsp_word,
    input  logic             epsilon_we,
    input  logic [EPS_W-1:0] epsilon_data
);

    logic [EPS_W-1:0] epsilon_reg;
    logic             q_full;
    logic             q_push;
    job_t             q_in;
    logic             q_pop;
    logic             q_not_empty;
    job_t             q_head;

    // The user must write the epsilon register only while no word is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPS_W'(66);
        end
        else if (epsilon_we)
        begin
            epsilon_reg <= epsilon_data;
        end
    end

    // The front end decodes each word and checks its channel.
    bn_front u_front
    (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .push      (q_push),
        .job       (q_in)
    );

    // The queue decouples acceptance from execution.
    bn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end holds the tables and carries out loads and normalizations.
    bn_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .epsilon     (epsilon_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_word    (rsp_word)
    );

endmodule
